>>> design/smf_pkg.sv
package smf_pkg;

  localparam int MAX_WINDOW  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AGE_W       = IDX_W;

  localparam logic [LEN_W-1:0] WL_RESET = LEN_W'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_W-1:0]              age_t;
  typedef logic [LEN_W-1:0]              len_t;
  typedef logic [IDX_W-1:0]              idx_t;

  // What a cell loads on a sample beat.
  typedef enum logic [1:0] {
    SEL_OWN   = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_RIGHT = 2'd2,
    SEL_NEW   = 2'd3
  } sel_t;

  typedef struct packed {
    sample_t val;
    age_t    age;
  } cell_data_t;

  typedef struct packed {
    logic le;   // stored value <= incoming sample
    logic del;  // this cell holds the oldest sample of a full window
  } cell_flags_t;

endpackage

>>> design/sliding_window_median_filter.sv
// Running median filter. Each input beat carries one signed sample; the
// block keeps the last L samples (L = window length register, 0 reads as
// 1, values above 32 read as 32) in a row of cells held in ascending
// order, each cell tagged with the age of its sample. On a sample beat,
// every cell compares its value with the new sample in parallel, the
// cell holding the oldest sample drops out, and the new sample is
// slotted in: each cell loads its own value, a neighbor's, or the new
// sample. Once L samples have arrived, every sample beat yields one
// result beat: the sorted element at index L/2 (upper middle for even
// L). Before the window fills, beats give no result. Writing the window
// length restarts the fill. Throughput is one sample per clock while the
// output is not stalled. The result is registered: the accepting edge
// settles the cell row, and the median tap then loads a separate output
// register as soon as that register is free.
// A stalled output holds one result in the output register and one more
// in the cell row; further samples wait until the output drains.
module sliding_window_median_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [smf_pkg::LEN_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [smf_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [smf_pkg::SAMPLE_BITS-1:0] out_median
);

  localparam int N = smf_pkg::MAX_WINDOW;

  // config and fill tracking
  smf_pkg::len_t wl_r;
  smf_pkg::len_t fill_r, fill_nxt;
  smf_pkg::len_t leff;
  smf_pkg::age_t oldest_age;
  smf_pkg::idx_t mid_idx;
  logic          win_full;
  logic          emit;

  // handshake
  logic accept;
  logic out_free;
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  smf_pkg::sample_t med_r;

  // cell row
  smf_pkg::cell_data_t  cd  [N];
  smf_pkg::cell_flags_t fl  [N];
  smf_pkg::sel_t        sel [N];
  logic [N-1:0] valid_v, del_v, keep_v, after_del, kc;
  logic [N:0]   keep_ext;
  logic [N-1:0] kc_lo, ad_lo;

  // effective length: zero acts as one, clipped to the row size
  always_comb begin
    if (wl_r == '0) begin
      leff = smf_pkg::len_t'(1);
    end else if (wl_r > smf_pkg::len_t'(N)) begin
      leff = smf_pkg::len_t'(N);
    end else begin
      leff = wl_r;
    end
  end

  assign oldest_age = smf_pkg::age_t'(leff - 1'b1);
  assign mid_idx    = smf_pkg::idx_t'(leff >> 1);
  assign win_full   = (fill_r == leff);
  assign emit       = win_full || (smf_pkg::len_t'(fill_r + 1'b1) == leff);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !pend_r || out_free;
  assign accept   = in_valid && in_ready;

  // Insert/delete steering. after_del[i]: the dropped cell sits at or
  // left of i, so the compacted row at i comes from cell i+1.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_v[i] = (smf_pkg::len_t'(i) < fill_r);
      del_v[i]   = fl[i].del;
      keep_v[i]  = valid_v[i] && fl[i].le && !fl[i].del;
    end
    after_del[0] = del_v[0];
    for (int i = 1; i < N; i++) begin
      after_del[i] = after_del[i-1] | del_v[i];
    end
    keep_ext = {1'b0, keep_v};
    for (int i = 0; i < N; i++) begin
      kc[i] = after_del[i] ? keep_ext[i+1] : keep_ext[i];
    end
    kc_lo = {kc[N-2:0], 1'b1};          // left of cell 0 counts as kept
    ad_lo = {after_del[N-2:0], 1'b0};
    for (int i = 0; i < N; i++) begin
      if (kc[i]) begin
        sel[i] = after_del[i] ? smf_pkg::SEL_RIGHT : smf_pkg::SEL_OWN;
      end else if (kc_lo[i]) begin
        sel[i] = smf_pkg::SEL_NEW;
      end else begin
        sel[i] = ad_lo[i] ? smf_pkg::SEL_OWN : smf_pkg::SEL_LEFT;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    smf_pkg::cell_data_t left_d, right_d;
    if (g == 0) begin : g_l0
      assign left_d = '0;
    end else begin : g_ln
      assign left_d = cd[g-1];
    end
    if (g == N - 1) begin : g_r0
      assign right_d = '0;
    end else begin : g_rn
      assign right_d = cd[g+1];
    end
    smf_cell u_cell (
      .clk        (clk),
      .cell_en    (accept),
      .sel        (sel[g]),
      .new_sample (in_sample),
      .oldest_age (oldest_age),
      .cell_valid (valid_v[g]),
      .win_full   (win_full),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cd[g]),
      .flags      (fl[g])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cfg_we) begin
      fill_nxt = '0;
    end else if (accept && !win_full) begin
      fill_nxt = smf_pkg::len_t'(fill_r + 1'b1);
    end
  end

  // pending result lives in the cell row until the output register frees
  assign pend_nxt      = (pend_r && !out_free) || (accept && emit);
  assign out_valid_nxt = (out_valid_r && !out_ready) || (pend_r && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= smf_pkg::WL_RESET;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wl_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      med_r <= cd[mid_idx].val;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = med_r;

  // fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= leff))
    else $error("fill count above window length");

  // a full window has exactly one oldest cell, otherwise none
  a_del_full: assert property (@(posedge clk) disable iff (!rst_n)
    win_full |-> $onehot(del_v))
    else $error("full window without a single oldest cell");

  a_del_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !win_full |-> (del_v == '0))
    else $error("cell dropped while window filling");

  // a sample beat on a full window always leaves a result pending
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && win_full && !cfg_we) |=> pend_r)
    else $error("full-window beat gave no result");

endmodule

>>> design/smf_cell.sv
module smf_cell (
  input  logic                      clk,
  input  logic                      cell_en,
  input  smf_pkg::sel_t             sel,
  input  smf_pkg::sample_t          new_sample,
  input  smf_pkg::age_t             oldest_age,
  input  logic                      cell_valid,
  input  logic                      win_full,
  input  smf_pkg::cell_data_t       left_data,
  input  smf_pkg::cell_data_t       right_data,
  output smf_pkg::cell_data_t       data,
  output smf_pkg::cell_flags_t      flags
);

  smf_pkg::cell_data_t data_r;
  smf_pkg::cell_data_t data_nxt;
  smf_pkg::cell_data_t src;

  always_comb begin
    case (sel)
      smf_pkg::SEL_LEFT:  src = left_data;
      smf_pkg::SEL_RIGHT: src = right_data;
      smf_pkg::SEL_NEW:   src = '{val: new_sample, age: '0};
      default:            src = data_r;
    endcase
    data_nxt.val = src.val;
    // every surviving sample grows one beat older; the new one starts at zero
    data_nxt.age = (sel == smf_pkg::SEL_NEW) ? '0 : smf_pkg::age_t'(src.age + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (cell_en) begin
      data_r <= data_nxt;
    end
  end

  assign data      = data_r;
  assign flags.le  = (data_r.val <= new_sample);
  assign flags.del = cell_valid && win_full && (data_r.age == oldest_age);

endmodule

>>> tb/sv/sliding_window_median_filter_test.sv
`timescale 1ns / 1ps

// Running median filter bench.
// A clocked driver feeds sample beats from a queue, a clocked monitor
// watches both channels, predicts each median from its own copy of the
// sample ring and compares every result beat in order.
module sliding_window_median_filter_test;

  localparam int unsigned SAMPLE_TARGET = 1400;
  localparam int unsigned MAX_ERR_LINES = 50;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  smf_pkg::len_t    cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  smf_pkg::sample_t in_sample = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  smf_pkg::sample_t out_median;

  sliding_window_median_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_median(out_median)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop; a correct run finishes far earlier.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor state: sample ring, its write slot, fill count and the
  // window length register as last written.
  // ---------------------------------------------------------------------
  smf_pkg::sample_t history [smf_pkg::MAX_WINDOW];
  int unsigned      hist_pos = 0;
  int unsigned      fill_cnt = 0;
  smf_pkg::len_t    win_len_reg = smf_pkg::WL_RESET;

  smf_pkg::sample_t sample_queue [$];     // beats not yet offered
  smf_pkg::sample_t pending_medians [$];  // medians owed by the block

  // Bookkeeping
  int unsigned errors = 0;
  int unsigned samples_sent = 0;
  int unsigned medians_seen = 0;
  int unsigned len_writes = 0;
  bit          sample_taken = 1'b0;  // input beat accepted at last rising edge
  bit          in_calm = 1'b0;       // phase with no input gaps
  bit          out_calm = 1'b0;      // phase with no output stalls
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;

  // Length the block actually uses: 0 behaves as 1, big values clamp.
  function automatic int unsigned span_of(smf_pkg::len_t l);
    if (l == 0) return 1;
    if (l > smf_pkg::MAX_WINDOW) return smf_pkg::MAX_WINDOW;
    return l;
  endfunction

  // Sort the newest span samples and pick index span/2 (upper middle).
  function automatic smf_pkg::sample_t window_median(int unsigned span);
    smf_pkg::sample_t ordered [smf_pkg::MAX_WINDOW];
    smf_pkg::sample_t v;
    int unsigned      k;
    int               j;
    for (k = 0; k < span; k++) begin
      v = history[(hist_pos + smf_pkg::MAX_WINDOW - 1 - k) % smf_pkg::MAX_WINDOW];
      j = k;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    return ordered[span / 2];
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample content: full range, a tight cluster (lots of ties),
  // the extremes, or values hugging the rails.
  function automatic smf_pkg::sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return smf_pkg::sample_t'($urandom);
    if (r < 75) return smf_pkg::sample_t'(int'($urandom_range(0, 8)) - 4);
    if (r < 87) begin
      case ($urandom_range(0, 3))
        0: return smf_pkg::sample_t'(16'sh8000);
        1: return smf_pkg::sample_t'(16'sh7fff);
        2: return smf_pkg::sample_t'(-1);
        default: return smf_pkg::sample_t'(0);
      endcase
    end
    if ($urandom_range(0, 1) == 1)
      return smf_pkg::sample_t'(32767 - int'($urandom_range(0, 3)));
    return smf_pkg::sample_t'(-32768 + int'($urandom_range(0, 3)));
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= MAX_ERR_LINES) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------
  // Input driver. Valid holds with its payload until the monitor saw the
  // beat taken; after each beat an idle gap may follow.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= sample_queue.pop_front();
        in_gap = in_calm ? 0 : draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: stalls start at random points, so they land on
  // every phase of the fill and steady state.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 5) == 0) out_hold = draw_gap();
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks result beats, tracks register writes and runs the
  // predictor on every accepted sample beat.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned      span;
    smf_pkg::sample_t want;
    sample_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        medians_seen++;
        if (pending_medians.size() == 0) begin
          flag_mismatch($sformatf("unexpected median %0d", out_median));
        end else begin
          want = pending_medians.pop_front();
          if (out_median !== want)
            flag_mismatch($sformatf("median got %0d want %0d", out_median, want));
        end
      end
      // Length write restarts the fill; the ring itself is kept.
      if (cfg_we) begin
        win_len_reg = cfg_wdata;
        fill_cnt    = 0;
      end
      if (in_valid && in_ready) begin
        sample_taken = 1'b1;
        history[hist_pos] = in_sample;
        hist_pos = (hist_pos + 1) % smf_pkg::MAX_WINDOW;
        span = span_of(win_len_reg);
        if (fill_cnt < span) fill_cnt++;
        // No median while the window is still filling.
        if (fill_cnt >= span) pending_medians.push_back(window_median(span));
      end
    end
  end

  // Wait until every sample is in and every owed median is out, then let the
  // bench idle before the next register write.
  task automatic wait_idle();
    @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_medians.size() != 0)
      @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_length(input smf_pkg::len_t value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    len_writes++;
  endtask

  task automatic queue_sample(input smf_pkg::sample_t s);
    sample_queue.push_back(s);
    samples_sent++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    smf_pkg::sample_t directed [18];
    smf_pkg::len_t    plan [8];
    int unsigned      p;
    int unsigned      n;
    int unsigned      count;
    smf_pkg::len_t    l;

    directed = '{16'sh7fff, 16'sh8000, 0, -1, 1, 16'sh7fff, 16'sh7fff,
                 16'sh8000, 16'sh8000, 0, 5, 5, 5, -5, 100, -100,
                 16'sh7ffe, 16'sh8001};
    // Zero acts as one, 33 and 63 clamp to 32, plus the ends of the range.
    plan = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd33, 6'd63, 6'd31, 6'd4};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: rail values at the reset length of 3, ties included.
    foreach (directed[i]) queue_sample(directed[i]);

    p = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      if (p < 8) begin
        l = plan[p];
      end else begin
        n = $urandom_range(0, 9);
        if (n < 7) l = smf_pkg::len_t'($urandom_range(0, 12));
        else if (n < 9) l = smf_pkg::len_t'($urandom_range(13, 32));
        else l = smf_pkg::len_t'($urandom_range(33, 63));
      end
      p++;
      write_length(l);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      // Enough beats to fill the window and then run well past it.
      count = span_of(l) + $urandom_range(4, 50);
      repeat (count) queue_sample(pick_sample());
    end

    // Drain.
    while (sample_queue.size() != 0 || in_valid) @(posedge clk);
    n = 0;
    while (pending_medians.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (pending_medians.size() != 0)
      flag_mismatch($sformatf("%0d medians never came out", pending_medians.size()));

    $display("run covered %0d sample beats, %0d median beats, %0d window length writes",
             samples_sent, medians_seen, len_writes);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
